### hdl/blink_pattern_generator_assert.svh
// Assertion macros for the blink pattern generator checker.
// No dependencies; the including module must declare clk_i and rst_ni.
`ifndef BLINK_PATTERN_GENERATOR_ASSERT_SVH
`define BLINK_PATTERN_GENERATOR_ASSERT_SVH

// Concurrent assertion clocked on clk_i and disabled while rst_ni is low.
`define BPG_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("blink pattern generator check failed");

// Same-cycle implication built on the clocked form above.
`define BPG_ASSERT_IMPLIES(lbl, ante, cons) \
  `BPG_ASSERT_CLK(lbl, (ante) |-> (cons))

`endif

### hdl/bpg_pkg.sv
// Package for the blink pattern generator: field widths, codes and states.
// No dependencies.
`timescale 1ns / 1ps

package bpg_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned TIME_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_STEADY    = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_FOREVER   = 8'hFE;
  localparam logic [COUNT_W-1:0] COUNT_RELOAD_AT = 8'hFD;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_RESET = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RELOAD,
    ST_FINISH
  } state_e;

endpackage

### hdl/bpg_in_if.sv
// Command channel of the blink pattern generator (valid/ready with payload).
// Depends on bpg_pkg for the field widths.
`timescale 1ns / 1ps

interface bpg_in_if;
  logic                            valid;
  logic                            ready;
  logic [bpg_pkg::OP_W-1:0]        operation;
  logic [bpg_pkg::ELAPSED_W-1:0]   elapsed_ms;
  logic [bpg_pkg::COUNT_W-1:0]     repeat_count;
  logic [bpg_pkg::TIME_W-1:0]      on_time_ms;
  logic [bpg_pkg::TIME_W-1:0]      off_time_ms;

  modport source (
    output valid, operation, elapsed_ms, repeat_count, on_time_ms, off_time_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, elapsed_ms, repeat_count, on_time_ms, off_time_ms,
    output ready
  );
endinterface

### hdl/bpg_out_if.sv
// Result channel of the blink pattern generator (valid/ready with payload).
// No dependencies.
`timescale 1ns / 1ps

interface bpg_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic start_accepted;
  logic keep_awake;

  modport source (
    output valid, pin_level, busy_res, start_accepted, keep_awake,
    input  ready
  );
  modport sink (
    input  valid, pin_level, busy_res, start_accepted, keep_awake,
    output ready
  );
endinterface

### hdl/blink_pattern_generator.sv
// Blink pattern generator top level: sequencer around one shared adder.
// Depends on bpg_pkg, bpg_in_if and bpg_out_if.
`timescale 1ns / 1ps

// One command is in flight at a time; in_i.ready is high only while the
// sequencer is idle. A tick that leaves the pattern running passes through
// the division state, and through the reload state when a forever pattern
// reloads: the position inside the period comes from a restoring division on
// the shared adder, one quotient bit per cycle over the PHASE_BITS+9 bits of
// remaining time. A tick that ends the pattern, finds a zero count or holds a
// steady pattern goes straight to the final state. An accepted start builds
// count * period by shift-and-add over the 8 count bits on the same adder.
// Reset, a start while busy and the unused code go straight to the final
// state. The result register frees the input side once it is loaded; a
// stalled result only holds the sequencer in its final state.
module blink_pattern_generator #(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpg_in_if.sink      in_i,
  bpg_out_if.source   out_o
);

  localparam int unsigned REM_BITS = PHASE_BITS + 9;
  localparam int unsigned PER_BITS = PHASE_BITS + 1;
  localparam int unsigned ALU_W    = REM_BITS + 1;
  localparam int unsigned STEP_W   = $clog2(REM_BITS);

  bpg_pkg::state_e state_q, state_d;

  logic [REM_BITS-1:0]       remaining_q, remaining_d;
  logic [bpg_pkg::COUNT_W-1:0] count_q, count_d;
  logic [PHASE_BITS-1:0]     on_q, on_d;
  logic [PHASE_BITS-1:0]     off_q, off_d;
  logic [PER_BITS-1:0]       period_q, period_d;
  logic                      busy_q, busy_d;
  logic                      level_q, level_d;
  logic                      acc_flag_q, acc_flag_d;
  logic                      awake_flag_q, awake_flag_d;
  logic                      out_valid_q, out_valid_d;

  logic [PER_BITS-1:0]       r_q, r_d;
  logic [REM_BITS-1:0]       dq_q, dq_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic                      res_level_q, res_busy_q, res_acc_q, res_awake_q;

  logic                      in_fire;
  logic                      res_load;
  bpg_pkg::op_e              op;
  logic [PHASE_BITS-1:0]     on_in, off_in;
  logic [PER_BITS-1:0]       period_eff;

  logic [ALU_W-1:0]          alu_a, alu_b;
  logic                      alu_sub;
  logic [ALU_W:0]            alu_sum;
  logic                      alu_carry;

  logic [PER_BITS:0]         trial;
  logic                      div_take;
  logic [PER_BITS-1:0]       r_next;
  logic [REM_BITS-1:0]       dq_next;
  logic [REM_BITS-1:0]       rem_sat;
  logic                      tick_stops;
  logic                      reload_hit;

  assign in_i.ready = (state_q == bpg_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign op         = bpg_pkg::op_e'(in_i.operation);
  assign on_in      = PHASE_BITS'(in_i.on_time_ms);
  assign off_in     = PHASE_BITS'(in_i.off_time_ms);
  assign res_load   = (state_q == bpg_pkg::ST_FINISH) && (!out_valid_q || out_o.ready);

  // A zero period only goes with zero remaining time; treat it as one.
  assign period_eff = (period_q == '0) ? PER_BITS'(1) : period_q;

  // Shared adder/subtractor. On subtract, carry out means a >= b.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      bpg_pkg::ST_IDLE: begin
        alu_a   = ALU_W'(remaining_q);
        alu_b   = ALU_W'(in_i.elapsed_ms);
        alu_sub = 1'b1;
      end
      bpg_pkg::ST_MUL: begin
        alu_a = {dq_q, 1'b0};
        alu_b = count_q[step_q[2:0]] ? ALU_W'(period_q) : '0;
      end
      bpg_pkg::ST_DIV: begin
        alu_a   = ALU_W'(trial);
        alu_b   = ALU_W'(period_eff);
        alu_sub = 1'b1;
      end
      bpg_pkg::ST_RELOAD: begin
        alu_a = ALU_W'(remaining_q);
        alu_b = ALU_W'(period_eff);
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{ALU_W{1'b0}}, alu_sub};
  assign alu_carry = alu_sum[ALU_W];

  // Restoring division step: dq shifts the dividend out and the quotient in.
  assign trial    = {r_q, dq_q[REM_BITS-1]};
  assign div_take = alu_carry;
  assign r_next   = div_take ? alu_sum[PER_BITS-1:0] : trial[PER_BITS-1:0];
  assign dq_next  = {dq_q[REM_BITS-2:0], div_take};

  assign rem_sat    = alu_carry ? alu_sum[REM_BITS-1:0] : '0;
  assign tick_stops = (count_q == bpg_pkg::COUNT_STEADY) || (count_q == '0)
                   || (rem_sat == '0);
  // remaining equals 253 periods exactly when the quotient is 253, no remainder.
  assign reload_hit = (count_q == bpg_pkg::COUNT_FOREVER)
                   && (dq_next == REM_BITS'(bpg_pkg::COUNT_RELOAD_AT))
                   && (r_next == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpg_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (op)
            bpg_pkg::OP_TICK:  state_d = tick_stops ? bpg_pkg::ST_FINISH : bpg_pkg::ST_DIV;
            bpg_pkg::OP_START: state_d = busy_q ? bpg_pkg::ST_FINISH : bpg_pkg::ST_MUL;
            default:           state_d = bpg_pkg::ST_FINISH;
          endcase
        end
      end
      bpg_pkg::ST_MUL: begin
        if (step_q == '0) state_d = bpg_pkg::ST_FINISH;
      end
      bpg_pkg::ST_DIV: begin
        if (step_q == '0) state_d = reload_hit ? bpg_pkg::ST_RELOAD : bpg_pkg::ST_FINISH;
      end
      bpg_pkg::ST_RELOAD: state_d = bpg_pkg::ST_FINISH;
      bpg_pkg::ST_FINISH: begin
        if (res_load) state_d = bpg_pkg::ST_IDLE;
      end
      default: state_d = bpg_pkg::ST_IDLE;
    endcase
  end

  // Datapath and flags.
  always_comb begin
    remaining_d  = remaining_q;
    count_d      = count_q;
    on_d         = on_q;
    off_d        = off_q;
    period_d     = period_q;
    busy_d       = busy_q;
    level_d      = level_q;
    acc_flag_d   = acc_flag_q;
    awake_flag_d = awake_flag_q;
    r_d          = r_q;
    dq_d         = dq_q;
    step_d       = step_q;
    case (state_q)
      bpg_pkg::ST_IDLE: begin
        if (in_fire) begin
          acc_flag_d   = 1'b0;
          awake_flag_d = 1'b0;
          case (op)
            bpg_pkg::OP_TICK: begin
              if (count_q == bpg_pkg::COUNT_STEADY) begin
                level_d = 1'b1;
                busy_d  = 1'b0;
              end else begin
                remaining_d = rem_sat;
                r_d         = '0;
                dq_d        = rem_sat;
                step_d      = STEP_W'(REM_BITS - 1);
                if (tick_stops) begin
                  level_d = 1'b0;
                  busy_d  = 1'b0;
                end
              end
            end
            bpg_pkg::OP_START: begin
              if (!busy_q) begin
                busy_d     = 1'b1;
                count_d    = in_i.repeat_count;
                on_d       = on_in;
                off_d      = off_in;
                period_d   = {1'b0, on_in} + {1'b0, off_in};
                acc_flag_d = 1'b1;
                dq_d       = '0;
                step_d     = STEP_W'(bpg_pkg::COUNT_W - 1);
              end
            end
            bpg_pkg::OP_RESET: begin
              remaining_d = '0;
              count_d     = '0;
              on_d        = '0;
              off_d       = '0;
              period_d    = '0;
              busy_d      = 1'b0;
              level_d     = 1'b0;
            end
            default: begin
              busy_d = busy_q;
            end
          endcase
        end
      end
      bpg_pkg::ST_MUL: begin
        dq_d   = alu_sum[REM_BITS-1:0];
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) remaining_d = alu_sum[REM_BITS-1:0];
      end
      bpg_pkg::ST_DIV: begin
        r_d    = r_next;
        dq_d   = dq_next;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          level_d      = (r_next > {1'b0, off_q});
          awake_flag_d = 1'b1;
        end
      end
      bpg_pkg::ST_RELOAD: begin
        remaining_d = alu_sum[REM_BITS-1:0];
      end
      default: begin
        step_d = step_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpg_pkg::ST_IDLE;
      remaining_q  <= '0;
      count_q      <= '0;
      on_q         <= '0;
      off_q        <= '0;
      period_q     <= '0;
      busy_q       <= 1'b0;
      level_q      <= 1'b0;
      acc_flag_q   <= 1'b0;
      awake_flag_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      remaining_q  <= remaining_d;
      count_q      <= count_d;
      on_q         <= on_d;
      off_q        <= off_d;
      period_q     <= period_d;
      busy_q       <= busy_d;
      level_q      <= level_d;
      acc_flag_q   <= acc_flag_d;
      awake_flag_q <= awake_flag_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    dq_q   <= dq_d;
    step_q <= step_d;
    if (res_load) begin
      res_level_q <= level_q;
      res_busy_q  <= busy_q;
      res_acc_q   <= acc_flag_q;
      res_awake_q <= awake_flag_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pin_level      = res_level_q;
  assign out_o.busy_res       = res_busy_q;
  assign out_o.start_accepted = res_acc_q;
  assign out_o.keep_awake     = res_awake_q;

endmodule

### hdl/bpg_chk.sv
// Port-level checker for the blink pattern generator, with its bind.
// Depends on blink_pattern_generator_assert.svh and the top level's ports.
`timescale 1ns / 1ps
`include "blink_pattern_generator_assert.svh"

module bpg_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic pin_level_i,
  input logic busy_res_i,
  input logic start_accepted_i,
  input logic keep_awake_i
);

  // A stalled result keeps its payload.
  `BPG_ASSERT_CLK(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable({pin_level_i, busy_res_i, start_accepted_i, keep_awake_i})))

  // Ready is low in the cycle after every command transfer.
  `BPG_ASSERT_CLK(a_busy_after_in, (in_valid_i && in_ready_i) |=> !in_ready_i)

  // An accepted start leaves a running pattern.
  `BPG_ASSERT_IMPLIES(a_start_busy, out_valid_i && start_accepted_i, busy_res_i)

  // Only a tick that leaves the pattern running asks to stay awake.
  `BPG_ASSERT_IMPLIES(a_awake_busy, out_valid_i && keep_awake_i, busy_res_i && !start_accepted_i)

endmodule

bind blink_pattern_generator bpg_chk u_bpg_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .pin_level_i      (out_o.pin_level),
  .busy_res_i       (out_o.busy_res),
  .start_accepted_i (out_o.start_accepted),
  .keep_awake_i     (out_o.keep_awake)
);
